[rtl/shp_pkg.sv]
// Shared types and constants for the separating hyperplane block.
// No dependencies; imported by every module of the block.
package shp_pkg;

  // Command codes carried by an input beat.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Result status codes.
  localparam logic [1:0] STAT_FACE   = 2'd0;
  localparam logic [1:0] STAT_VERTEX = 2'd1;
  localparam logic [1:0] STAT_FAR    = 2'd2;
  localparam logic [1:0] STAT_ZERO   = 2'd3;

  // Fixed field widths.
  localparam int IDX_W  = 10;
  localparam int SLOT_W = 5;
  localparam int WORD_W = 32;
  localparam int NRM_W  = 18;
  localparam int TOL_W  = 17;
  localparam logic [TOL_W-1:0] TOL_RESET = 17'd655;

  // One command as it waits between the front and the back.
  typedef struct packed {
    logic                     command;
    logic [IDX_W-1:0]         obstacle_index;
    logic [SLOT_W-1:0]        word_slot;
    logic signed [WORD_W-1:0] load_value;
    logic signed [WORD_W-1:0] point_x;
    logic signed [WORD_W-1:0] point_y;
  } cmd_item_t;

endpackage

[rtl/shp_front.sv]
// Front end: takes command beats and holds them in a two-entry queue.
// Depends on shp_pkg for the command item type.
module shp_front
  import shp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  cmd_item_t in_item,
  output logic      q_valid,
  output cmd_item_t q_head,
  input  logic      q_pop
);

  cmd_item_t   mem_r [2];
  logic        wp_r;
  logic        rp_r;
  logic [1:0]  cnt_r;
  logic        push;

  // The queue is full at two entries; that is the only time the front stalls.
  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = mem_r[rp_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

[rtl/shp_back.sv]
// Back end: obstacle table memories and the query sequencer (nearest vertex,
// face test, normalization by iterative square root and division, offset).
// Depends on shp_pkg.
module shp_back
  import shp_pkg::*;
#(
  parameter int OBSTACLE_COUNT = 1024,
  parameter int FACE_COUNT     = 4,
  parameter int FRACTION_BITS  = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [TOL_W-1:0]         tolerance,
  input  logic                     q_valid,
  input  cmd_item_t                q_head,
  output logic                     q_pop,
  output logic                     res_valid,
  output logic signed [NRM_W-1:0]  res_normal_x,
  output logic signed [NRM_W-1:0]  res_normal_y,
  output logic signed [WORD_W-1:0] res_offset,
  output logic [1:0]               res_status
);

  localparam int F     = FACE_COUNT;
  localparam int FB    = FRACTION_BITS;
  localparam int VDEP  = OBSTACLE_COUNT * 2 * F;
  localparam int ODEP  = OBSTACLE_COUNT * F;
  localparam int VAW   = (VDEP > 1) ? $clog2(VDEP) : 1;
  localparam int OAW   = (ODEP > 1) ? $clog2(ODEP) : 1;
  localparam int AAW   = (OBSTACLE_COUNT > 1) ? $clog2(OBSTACLE_COUNT) : 1;
  localparam int KW    = $clog2(F);
  localparam int NUMW  = 31 + FB + 1;
  localparam int QW    = FB + 1;
  localparam int NW    = FB + 2;
  localparam logic [62:0] LIMIT = 63'(1000) << (2 * FB);

  // Sequencer states.
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_VX   = 5'd1;
  localparam logic [4:0] S_VY   = 5'd2;
  localparam logic [4:0] S_VD   = 5'd3;
  localparam logic [4:0] S_VM   = 5'd4;
  localparam logic [4:0] S_VS   = 5'd5;
  localparam logic [4:0] S_FCHK = 5'd6;
  localparam logic [4:0] S_FNY  = 5'd7;
  localparam logic [4:0] S_FP1  = 5'd8;
  localparam logic [4:0] S_FP2  = 5'd9;
  localparam logic [4:0] S_WSEL = 5'd10;
  localparam logic [4:0] S_NRM  = 5'd11;
  localparam logic [4:0] S_SQ1  = 5'd12;
  localparam logic [4:0] S_SQ2  = 5'd13;
  localparam logic [4:0] S_SQRT = 5'd14;
  localparam logic [4:0] S_DIVI = 5'd15;
  localparam logic [4:0] S_DIV  = 5'd16;
  localparam logic [4:0] S_SGN  = 5'd17;
  localparam logic [4:0] S_OF1  = 5'd18;
  localparam logic [4:0] S_OF2  = 5'd19;

  // Table memories.
  logic signed [WORD_W-1:0] vmem [VDEP];
  logic signed [WORD_W-1:0] omem [ODEP];
  logic signed [WORD_W-1:0] nmem [VDEP];
  logic [WORD_W-1:0]        amem [OBSTACLE_COUNT];
  logic signed [WORD_W-1:0] v_q, o_q, n_q;
  logic [WORD_W-1:0]        a_q;

  logic [4:0]               state_r;
  cmd_item_t                item_r;
  logic [KW-1:0]            k_r, near_r;
  logic                     found_r;
  logic [62:0]              best_r;
  logic signed [WORD_W-1:0] cand_x_r, cand_y_r, vx_r, vy_r;
  logic [32:0]              dxa_r, dya_r;
  logic [61:0]              sq_r;
  logic signed [WORD_W-1:0] nrm_x_r, nrm_y_r, face_x_r, face_y_r;
  logic signed [63:0]       fprod_r;
  logic [1:0]               mark_r;
  logic [1:0]               st_r;
  logic                     wx_neg_r, wy_neg_r;
  logic [32:0]              ux_r, uy_r;
  logic [62:0]              n_r, root_r, bit_r;
  logic [4:0]               cnt_r;
  logic [31:0]              len_r, rem_x_r, rem_y_r;
  logic [FB:0]              lo_x_r, lo_y_r;
  logic [QW-1:0]            q_x_r, q_y_r;
  logic signed [NW-1:0]     nx_r, ny_r;
  logic signed [63:0]       oprod_r;

  // Load decode on the head of the queue.
  int   h_idx, h_slot;
  logic load_go, v_we, o_we, n_we, a_we;
  logic [VAW-1:0] v_waddr, n_waddr, v_raddr, n_raddr;
  logic [OAW-1:0] o_waddr, o_raddr;
  logic [AAW-1:0] a_waddr, a_raddr;

  assign q_pop = (state_r == S_IDLE) && q_valid;

  always_comb begin
    h_idx   = int'(q_head.obstacle_index);
    h_slot  = int'(q_head.word_slot);
    load_go = q_pop && (q_head.command == CMD_LOAD) && (h_idx < OBSTACLE_COUNT);
    v_we    = load_go && (h_slot < 2 * F);
    o_we    = load_go && (h_slot >= 2 * F) && (h_slot < 3 * F);
    n_we    = load_go && (h_slot >= 3 * F) && (h_slot < 5 * F);
    a_we    = load_go && (h_slot == 5 * F);
    v_waddr = VAW'(h_idx * 2 * F + h_slot);
    o_waddr = OAW'(h_idx * F + h_slot - 2 * F);
    n_waddr = VAW'(h_idx * 2 * F + h_slot - 3 * F);
    a_waddr = AAW'(h_idx);
    v_raddr = VAW'(int'(item_r.obstacle_index) * 2 * F + 2 * int'(k_r)
                   + int'(state_r == S_VY));
    n_raddr = VAW'(int'(item_r.obstacle_index) * 2 * F + 2 * int'(k_r)
                   + int'(state_r == S_FNY));
    o_raddr = OAW'(int'(item_r.obstacle_index) * F + int'(k_r));
    a_raddr = AAW'(int'(item_r.obstacle_index));
  end

  // Memories: one write and one registered read each per cycle.
  always_ff @(posedge clk) begin
    if (v_we) begin
      vmem[v_waddr] <= q_head.load_value;
    end
    v_q <= vmem[v_raddr];
  end

  always_ff @(posedge clk) begin
    if (o_we) begin
      omem[o_waddr] <= q_head.load_value;
    end
    o_q <= omem[o_raddr];
  end

  always_ff @(posedge clk) begin
    if (n_we) begin
      nmem[n_waddr] <= q_head.load_value;
    end
    n_q <= nmem[n_raddr];
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      amem[a_waddr] <= q_head.load_value;
    end
    a_q <= amem[a_raddr];
  end

  // Datapath helpers for the current state.
  logic                     last_k;
  int                       adj_bit;
  logic                     adj_hit;
  logic [61:0]              sq_y;
  logic [61:0]              sq_uy;
  logic [62:0]              dist_sum;
  logic signed [63:0]       fprod_y, fval;
  logic signed [32:0]       wx, wy, dx, dy;
  logic [32:0]              mx;
  logic [63:0]              trial;
  logic [NUMW-1:0]          num_x, num_y;
  logic [32:0]              t_x, t_y;
  logic                     ge_x, ge_y;
  logic signed [63:0]       osum, oshift;

  always_comb begin
    last_k  = (k_r == KW'(F - 1));
    adj_bit = int'(near_r) * F + int'(k_r);
    adj_hit = (adj_bit < 32) && a_q[adj_bit[4:0]];
    dx      = 33'(item_r.point_x) - 33'(cand_x_r);
    dy      = 33'(item_r.point_y) - 33'(v_q);
    sq_y    = dya_r[30:0] * dya_r[30:0];
    sq_uy   = uy_r[30:0] * uy_r[30:0];
    dist_sum = {1'b0, sq_r} + {1'b0, sq_y};
    fprod_y = (64'(nrm_y_r) * 64'(item_r.point_y)) >>> FB;
    fval    = fprod_r + fprod_y - 64'(o_q);
    if (mark_r == 2'd1) begin
      wx = 33'(face_x_r);
      wy = 33'(face_y_r);
    end else begin
      wx = 33'(item_r.point_x) - 33'(vx_r);
      wy = 33'(item_r.point_y) - 33'(vy_r);
    end
    mx      = (ux_r > uy_r) ? ux_r : uy_r;
    trial   = {1'b0, root_r} + {1'b0, bit_r};
    num_x   = {ux_r[30:0], {FB{1'b0}}} + NUMW'(root_r[31:1]);
    num_y   = {uy_r[30:0], {FB{1'b0}}} + NUMW'(root_r[31:1]);
    t_x     = {rem_x_r, lo_x_r[FB]};
    t_y     = {rem_y_r, lo_y_r[FB]};
    ge_x    = (t_x >= {1'b0, len_r});
    ge_y    = (t_y >= {1'b0, len_r});
    osum    = oprod_r + 64'(ny_r) * 64'(vy_r);
    oshift  = osum >>> FB;
  end

  // Query sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_pop && (q_head.command == CMD_QUERY)) begin
            item_r  <= q_head;
            k_r     <= '0;
            best_r  <= LIMIT;
            found_r <= 1'b0;
            mark_r  <= 2'd0;
            if (int'(q_head.obstacle_index) >= OBSTACLE_COUNT) begin
              res_valid    <= 1'b1;
              res_normal_x <= '0;
              res_normal_y <= '0;
              res_offset   <= '0;
              res_status   <= STAT_FAR;
            end else begin
              state_r <= S_VX;
            end
          end
        end
        // Vertex scan: read x, read y, take differences, square, compare.
        S_VX: state_r <= S_VY;
        S_VY: begin
          cand_x_r <= v_q;
          state_r  <= S_VD;
        end
        S_VD: begin
          cand_y_r <= v_q;
          dxa_r    <= dx[32] ? 33'(-dx) : 33'(dx);
          dya_r    <= dy[32] ? 33'(-dy) : 33'(dy);
          state_r  <= S_VM;
        end
        S_VM: begin
          sq_r    <= dxa_r[30:0] * dxa_r[30:0];
          state_r <= S_VS;
        end
        S_VS: begin
          if (!(dxa_r[32] || dxa_r[31] || dya_r[32] || dya_r[31]) && (dist_sum < best_r)) begin
            best_r  <= dist_sum;
            near_r  <= k_r;
            found_r <= 1'b1;
            vx_r    <= cand_x_r;
            vy_r    <= cand_y_r;
          end
          if (last_k) begin
            k_r <= '0;
            if (!found_r && !(!(dxa_r[32] || dxa_r[31] || dya_r[32] || dya_r[31])
                              && (dist_sum < best_r))) begin
              res_valid    <= 1'b1;
              res_normal_x <= '0;
              res_normal_y <= '0;
              res_offset   <= '0;
              res_status   <= STAT_FAR;
              state_r      <= S_IDLE;
            end else begin
              state_r <= S_FCHK;
            end
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_VX;
          end
        end
        // Face scan over faces adjacent to the nearest vertex.
        S_FCHK: begin
          if (adj_hit) begin
            state_r <= S_FNY;
          end else if (last_k) begin
            state_r <= S_WSEL;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_FNY: begin
          nrm_x_r <= n_q;
          state_r <= S_FP1;
        end
        S_FP1: begin
          nrm_y_r <= n_q;
          fprod_r <= (64'(nrm_x_r) * 64'(item_r.point_x)) >>> FB;
          state_r <= S_FP2;
        end
        S_FP2: begin
          if (fval > -$signed(64'(tolerance))) begin
            if (mark_r != 2'd2) begin
              mark_r <= mark_r + 2'd1;
            end
            face_x_r <= nrm_x_r;
            face_y_r <= nrm_y_r;
          end
          if (last_k) begin
            state_r <= S_WSEL;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_FCHK;
          end
        end
        // Pick the vector and take its magnitudes.
        S_WSEL: begin
          st_r     <= (mark_r == 2'd1) ? STAT_FACE : STAT_VERTEX;
          wx_neg_r <= wx[32];
          wy_neg_r <= wy[32];
          ux_r     <= wx[32] ? 33'(-wx) : 33'(wx);
          uy_r     <= wy[32] ? 33'(-wy) : 33'(wy);
          if ((wx == '0) && (wy == '0)) begin
            res_valid    <= 1'b1;
            res_normal_x <= '0;
            res_normal_y <= '0;
            res_offset   <= '0;
            res_status   <= STAT_ZERO;
            state_r      <= S_IDLE;
          end else begin
            state_r <= S_NRM;
          end
        end
        // Bring the larger magnitude into [2^30, 2^31), one bit a cycle.
        S_NRM: begin
          if (mx[32] || mx[31]) begin
            ux_r <= ux_r >> 1;
            uy_r <= uy_r >> 1;
          end else if (!mx[30]) begin
            ux_r <= ux_r << 1;
            uy_r <= uy_r << 1;
          end else begin
            state_r <= S_SQ1;
          end
        end
        S_SQ1: begin
          sq_r    <= ux_r[30:0] * ux_r[30:0];
          state_r <= S_SQ2;
        end
        S_SQ2: begin
          n_r     <= {1'b0, sq_r} + {1'b0, sq_uy};
          root_r  <= '0;
          bit_r   <= 63'(1) << 62;
          cnt_r   <= 5'd31;
          state_r <= S_SQRT;
        end
        // Integer square root, one result bit a cycle.
        S_SQRT: begin
          if ({1'b0, n_r} >= trial) begin
            n_r    <= n_r - trial[62:0];
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) begin
            state_r <= S_DIVI;
          end
        end
        // Rounded divisions of both magnitudes by the length, in parallel.
        S_DIVI: begin
          len_r   <= root_r[31:0];
          rem_x_r <= 32'(num_x[NUMW-1:FB+1]);
          rem_y_r <= 32'(num_y[NUMW-1:FB+1]);
          lo_x_r  <= num_x[FB:0];
          lo_y_r  <= num_y[FB:0];
          q_x_r   <= '0;
          q_y_r   <= '0;
          cnt_r   <= 5'(FB);
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_x_r <= ge_x ? 32'(t_x - {1'b0, len_r}) : t_x[31:0];
          rem_y_r <= ge_y ? 32'(t_y - {1'b0, len_r}) : t_y[31:0];
          lo_x_r  <= lo_x_r << 1;
          lo_y_r  <= lo_y_r << 1;
          q_x_r   <= {q_x_r[QW-2:0], ge_x};
          q_y_r   <= {q_y_r[QW-2:0], ge_y};
          cnt_r   <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) begin
            state_r <= S_SGN;
          end
        end
        S_SGN: begin
          nx_r    <= wx_neg_r ? -$signed({1'b0, q_x_r}) : $signed({1'b0, q_x_r});
          ny_r    <= wy_neg_r ? -$signed({1'b0, q_y_r}) : $signed({1'b0, q_y_r});
          state_r <= S_OF1;
        end
        // Offset: normal dotted with the vertex, floored and saturated.
        S_OF1: begin
          oprod_r <= 64'(nx_r) * 64'(vx_r);
          state_r <= S_OF2;
        end
        S_OF2: begin
          res_valid    <= 1'b1;
          res_normal_x <= NRM_W'(nx_r);
          res_normal_y <= NRM_W'(ny_r);
          res_status   <= st_r;
          if (oshift > 64'sd2147483647) begin
            res_offset <= 32'sh7FFFFFFF;
          end else if (oshift < -64'sd2147483648) begin
            res_offset <= 32'sh80000000;
          end else begin
            res_offset <= oshift[31:0];
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/separating_hyperplane_from_polygon.sv]
// Top level of the separating hyperplane block: tolerance register, front
// queue and back sequencer. Depends on shp_pkg, shp_front and shp_back.
//
// Usage: a command beat is taken at a clock edge where start is high and busy
// is low. Command 0 loads one table word (no result); command 1 queries the
// hyperplane between a point and an obstacle and gives exactly one result.
// Results appear for one cycle with out_valid high and must be taken then;
// the receiver cannot stall the block.
// Beats wait in a two-entry queue, so busy rises only when that queue is full.
// A load is written to its table as it leaves the queue. A query scans
// every vertex, tests each face adjacent to the nearest vertex, shifts to
// normalize, then runs a serial square root, a serial division and the
// sign and offset steps before its result. A query with an out-of-range
// index skips the scan and answers with the far status.
// cfg_we writes the face tolerance; reset sets it to 0.01 and empties the
// queue. Table contents are not cleared by reset and must be loaded first.
module separating_hyperplane_from_polygon
  import shp_pkg::*;
#(
  parameter int OBSTACLE_COUNT = 1024,
  parameter int FACE_COUNT     = 4,
  parameter int FRACTION_BITS  = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [TOL_W-1:0]         cfg_data,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_command,
  input  logic [IDX_W-1:0]         in_obstacle_index,
  input  logic [SLOT_W-1:0]        in_word_slot,
  input  logic signed [WORD_W-1:0] in_load_value,
  input  logic signed [WORD_W-1:0] in_point_x,
  input  logic signed [WORD_W-1:0] in_point_y,
  output logic                     out_valid,
  output logic signed [NRM_W-1:0]  out_normal_x,
  output logic signed [NRM_W-1:0]  out_normal_y,
  output logic signed [WORD_W-1:0] out_plane_offset,
  output logic [1:0]               out_status
);

  logic [TOL_W-1:0] tol_r;
  cmd_item_t        in_item;
  cmd_item_t        q_head;
  logic             q_valid;
  logic             q_pop;

  // Face tolerance register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_data;
    end
  end

  // Pack the input beat.
  always_comb begin
    in_item.command        = in_command;
    in_item.obstacle_index = in_obstacle_index;
    in_item.word_slot      = in_word_slot;
    in_item.load_value     = in_load_value;
    in_item.point_x        = in_point_x;
    in_item.point_y        = in_point_y;
  end

  shp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  shp_back #(
    .OBSTACLE_COUNT (OBSTACLE_COUNT),
    .FACE_COUNT     (FACE_COUNT),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .tolerance    (tol_r),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .res_valid    (out_valid),
    .res_normal_x (out_normal_x),
    .res_normal_y (out_normal_y),
    .res_offset   (out_plane_offset),
    .res_status   (out_status)
  );

endmodule
